FILE: hw/rtl/sacl_pkg.sv
// sacl_pkg: shared constants, types and helpers for the cache tag lookup unit
// used by sacl_apb, set_assoc_cache_tag_lookup_unit and sacl_checker
// no dependencies
`default_nettype none

package sacl_pkg;

    // cache geometry
    localparam int LINES        = 2048;
    localparam int MAX_WAYS     = 8;
    localparam int LINE_BITS    = $clog2(LINES);
    localparam int WAY_BITS_MAX = $clog2(MAX_WAYS);

    // field widths
    localparam int ADDR_W   = 32;
    localparam int WAY_W    = 3;
    localparam int CNT_W    = 32;
    localparam int OFFSET_W = 4;
    localparam int WAYB_W   = 2;

    // a stored tag never needs more than these bits
    localparam int TAG_W   = ADDR_W - LINE_BITS + WAY_BITS_MAX;
    localparam int ENTRY_W = TAG_W + 1;
    localparam int SHIFT_W = $clog2(LINE_BITS + 1);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd4;
    localparam logic [WAYB_W-1:0]   WAYB_RESET   = 2'd3;

    // victim lfsr
    localparam int              LFSR_W    = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef enum logic {
        REG_OFFSET_BITS = 1'b0,
        REG_WAY_BITS    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_bits;
        logic [WAYB_W-1:0]   way_bits;
    } cfg_t;

    // right-shifting lfsr, taps 16,14,13,11
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        return {b, s[LFSR_W-1:1]};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sacl_ram.sv
// sacl_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sacl_apb.sv
// sacl_apb: apb-style configuration registers (offset_bits, way_bits)
// depends on sacl_pkg
`default_nettype none

module sacl_apb
    import sacl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_OFFSET_BITS: cfg_next.offset_bits = pwdata[OFFSET_W-1:0];
                REG_WAY_BITS:    cfg_next.way_bits    = pwdata[WAYB_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_OFFSET_BITS: prdata = {{(PDATA_W-OFFSET_W){1'b0}}, cfg_reg.offset_bits};
            REG_WAY_BITS:    prdata = {{(PDATA_W-WAYB_W){1'b0}}, cfg_reg.way_bits};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= OFFSET_RESET;
            cfg_reg.way_bits    <= WAYB_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_cache_tag_lookup_unit.sv
// set_assoc_cache_tag_lookup_unit: top level of the cache tag lookup unit
// depends on sacl_pkg, sacl_ram and sacl_apb
`default_nettype none

// Set-associative tag lookup with random replacement, one address per item.
// The ways of a set are read from a single tag ram one way per cycle and
// checked by one shared tag comparator under a small sequencer; the scan
// stops at the first way whose tag matches, else runs through all W ways in
// use (W = ways in use), and a miss then writes the new tag into the chosen way.
// Only one item is in flight; the result sits in an output register, so a
// new item is taken while the previous result waits. After reset a clearing
// pass over every line zeroes the valid bits and no item is accepted until it
// ends; configuration writes are taken throughout. The hit and miss counts
// saturate at all ones. The victim lfsr advances once per item.
module set_assoc_cache_tag_lookup_unit
    import sacl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    // request
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [ADDR_W-1:0]  address,
    // response
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic                    hit,
    output logic                    filled_empty,
    output logic      [WAY_W-1:0]   way,
    output logic      [CNT_W-1:0]   hit_count,
    output logic      [CNT_W-1:0]   miss_count
);

    cfg_t cfg;

    state_t state_reg, state_next;

    // per-item registers
    logic [TAG_W-1:0]     tag_reg;
    logic [LINE_BITS-1:0] base_reg;
    logic [WAY_W-1:0]     last_way_reg;
    logic [WAY_W-1:0]     way_cnt_reg;
    logic                 inv_found_reg;
    logic [WAY_W-1:0]     inv_way_reg;
    logic                 res_hit_reg;
    logic                 res_filled_reg;
    logic [WAY_W-1:0]     res_way_reg;
    logic [LINE_BITS-1:0] clear_cnt_reg;

    // persistent state
    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  misses_reg;
    logic [LFSR_W-1:0] lfsr_reg;

    // output register
    logic             rsp_valid_reg;
    logic             out_hit_reg;
    logic             out_filled_reg;
    logic [WAY_W-1:0] out_way_reg;
    logic [CNT_W-1:0] out_hits_reg;
    logic [CNT_W-1:0] out_misses_reg;

    // address split for the incoming item
    logic [WAYB_W-1:0]    wb_eff;
    logic [ADDR_W-1:0]    block;
    logic [TAG_W-1:0]     tag_in;
    logic [LINE_BITS-1:0] base_in;
    logic [WAY_W-1:0]     last_way_in;

    // ram interface
    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [LINE_BITS-1:0] ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    // scan decisions
    logic             rd_valid;
    logic             scan_match;
    logic             scan_last;
    logic             req_fire;
    logic             commit;
    logic             miss_filled;
    logic [WAY_W-1:0] miss_way;
    logic [WAY_W-1:0] victim_way;
    logic             clear_done;

    sacl_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sacl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LINES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ways in use, capped at the physical ways
    always_comb
    begin
        if (cfg.way_bits > WAYB_W'(WAY_BITS_MAX))
        begin
            wb_eff = WAYB_W'(WAY_BITS_MAX);
        end
        else
        begin
            wb_eff = cfg.way_bits;
        end
    end

    // set and tag of the incoming address
    assign block       = address >> cfg.offset_bits;
    assign tag_in      = TAG_W'(block >> (SHIFT_W'(LINE_BITS) - SHIFT_W'(wb_eff)));
    assign base_in     = LINE_BITS'(block << wb_eff);
    assign last_way_in = WAY_W'((32'd1 << wb_eff) - 32'd1);

    // shared tag compare on the way just read
    assign rd_valid   = ram_rdata[TAG_W];
    assign scan_match = rd_valid && (ram_rdata[TAG_W-1:0] == tag_reg);
    assign scan_last  = (way_cnt_reg == last_way_reg);
    assign victim_way = lfsr_reg[WAY_W-1:0] & last_way_reg;
    assign clear_done = (clear_cnt_reg == {LINE_BITS{1'b1}});

    // miss way choice: lowest invalid way, else the lfsr victim
    always_comb
    begin
        if (inv_found_reg)
        begin
            miss_filled = 1'b1;
            miss_way    = inv_way_reg;
        end
        else if (!rd_valid)
        begin
            miss_filled = 1'b1;
            miss_way    = way_cnt_reg;
        end
        else
        begin
            miss_filled = 1'b0;
            miss_way    = victim_way;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_match || scan_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        commit    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = base_reg | LINE_BITS'(res_way_reg);
        ram_wdata = {1'b1, tag_reg};
        ram_raddr = base_reg | LINE_BITS'(WAY_W'(way_cnt_reg + 1'b1));
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                ram_raddr = base_in;
            end
            ST_SCAN:
            begin
            end
            ST_FINISH:
            begin
                ram_we = !res_hit_reg;
                commit = !rsp_valid_reg || rsp_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign req_fire = req_valid && req_ready;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            lfsr_reg      <= LFSR_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            if (commit)
            begin
                lfsr_reg      <= lfsr_next(lfsr_reg);
                rsp_valid_reg <= 1'b1;
                if (res_hit_reg)
                begin
                    if (hits_reg != {CNT_W{1'b1}})
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                else if (misses_reg != {CNT_W{1'b1}})
                begin
                    misses_reg <= misses_reg + 1'b1;
                end
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // per-item datapath
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            tag_reg       <= tag_in;
            base_reg      <= base_in;
            last_way_reg  <= last_way_in;
            way_cnt_reg   <= '0;
            inv_found_reg <= 1'b0;
        end
        else if (state_reg == ST_SCAN)
        begin
            if (scan_match)
            begin
                res_hit_reg    <= 1'b1;
                res_filled_reg <= 1'b0;
                res_way_reg    <= way_cnt_reg;
            end
            else if (scan_last)
            begin
                res_hit_reg    <= 1'b0;
                res_filled_reg <= miss_filled;
                res_way_reg    <= miss_way;
            end
            else
            begin
                way_cnt_reg <= way_cnt_reg + 1'b1;
                if (!rd_valid && !inv_found_reg)
                begin
                    inv_found_reg <= 1'b1;
                    inv_way_reg   <= way_cnt_reg;
                end
            end
        end
    end

    // output register load
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_hit_reg    <= res_hit_reg;
            out_filled_reg <= res_filled_reg;
            out_way_reg    <= res_way_reg;
            if (res_hit_reg && (hits_reg != {CNT_W{1'b1}}))
            begin
                out_hits_reg <= hits_reg + 1'b1;
            end
            else
            begin
                out_hits_reg <= hits_reg;
            end
            if (!res_hit_reg && (misses_reg != {CNT_W{1'b1}}))
            begin
                out_misses_reg <= misses_reg + 1'b1;
            end
            else
            begin
                out_misses_reg <= misses_reg;
            end
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = out_hit_reg;
    assign filled_empty = out_filled_reg;
    assign way          = out_way_reg;
    assign hit_count    = out_hits_reg;
    assign miss_count   = out_misses_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sacl_checker.sv
// sacl_checker: port-level assertions for the cache tag lookup unit, with bind
// depends on sacl_pkg; binds to set_assoc_cache_tag_lookup_unit
`default_nettype none

module sacl_checker
    import sacl_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             req_valid,
    input wire logic             req_ready,
    input wire logic             rsp_valid,
    input wire logic             rsp_ready,
    input wire logic             hit,
    input wire logic             filled_empty,
    input wire logic [WAY_W-1:0] way,
    input wire logic [CNT_W-1:0] hit_count,
    input wire logic [CNT_W-1:0] miss_count
);

    // a stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(hit) && $stable(filled_empty) && $stable(way)
            && $stable(hit_count) && $stable(miss_count))
        else $error("stalled result payload changed");

    // a hit never reports a fill
    a_hit_not_filled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(hit && filled_empty))
        else $error("result flags both hit and fill");

    // one item in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while previous item in flight");

    // counters never go backwards across results
    a_counts_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && $past(rsp_valid) |->
            (hit_count >= $past(hit_count)) && (miss_count >= $past(miss_count)))
        else $error("hit or miss count decreased");

endmodule

bind set_assoc_cache_tag_lookup_unit sacl_checker u_checker (.*);

`default_nettype wire
